@@ sv/fmi_pkg.sv @@
// ----------------------------------------------------------------------------
// fmi_pkg
// Shared constants, codes and types of the FM-index backward search engine.
// ----------------------------------------------------------------------------
package fmi_pkg;

  localparam int TEXT_MAX    = 4096;
  localparam int PATTERN_MAX = 64;
  localparam int TEXT_AW     = $clog2(TEXT_MAX);
  localparam int CNT_W       = TEXT_AW + 1;
  localparam int PAT_AW      = $clog2(PATTERN_MAX);
  localparam int PLEN_W      = PAT_AW + 1;
  localparam int BYTE_W      = 8;
  localparam int SYM_N       = 256;
  localparam int SYM_AW      = 8;
  localparam int BKT_DEPTH   = TEXT_MAX + 1;
  localparam int Q_DEPTH     = 2;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int Q_CW        = $clog2(Q_DEPTH + 1);

  localparam logic [BYTE_W-1:0] SENT_RESET = 8'd36;

  localparam logic [1:0] OP_TEXT    = 2'd0;
  localparam logic [1:0] OP_PATTERN = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [1:0] KIND_BUILT  = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_POS    = 2'd2;

  localparam logic [1:0] CMD_BUILD  = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [CNT_W-1:0]   len;
    logic [TEXT_AW-1:0] row;
    logic               ovf;
  } cmd_t;

  typedef struct packed {
    logic build_done;
    logic search_done;
  } back_status_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [CNT_W-1:0]   count;
    logic [TEXT_AW-1:0] start;
    logic [TEXT_AW-1:0] pos;
    logic               ovf;
  } result_t;

endpackage

@@ sv/fmi_ram.sv @@
// ----------------------------------------------------------------------------
// fmi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fmi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/fmi_queue.sv @@
// ----------------------------------------------------------------------------
// fmi_queue
// Short command queue between the front end and the execution engine.
// ----------------------------------------------------------------------------
module fmi_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fmi_pkg::cmd_t push_cmd,
  input  logic          pop,
  output fmi_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import fmi_pkg::*;

  cmd_t            ent_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r;
  logic [Q_AW-1:0] rp_r;
  logic [Q_CW-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= wp_r + Q_AW'(1);
      end
      if (pop && !empty) begin
        rp_r <= rp_r + Q_AW'(1);
      end
      priority if ((push && !full) && !(pop && !empty)) begin
        cnt_r <= cnt_r + Q_CW'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        cnt_r <= cnt_r - Q_CW'(1);
      end
    end
  end

endmodule

@@ sv/fmi_front.sv @@
// ----------------------------------------------------------------------------
// fmi_front
// Accepts transactions, buffers text and pattern bytes, appends the
// terminator and issues build, search and read commands.
// ----------------------------------------------------------------------------
module fmi_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_operation,
  input  logic [fmi_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                         in_last,
  input  logic [fmi_pkg::TEXT_AW-1:0]  in_sa_index,
  input  logic                         cfg_we,
  input  logic [fmi_pkg::BYTE_W-1:0]   cfg_wdata,
  output logic                         text_we,
  output logic [fmi_pkg::TEXT_AW-1:0]  text_waddr,
  output logic [fmi_pkg::BYTE_W-1:0]   text_wdata,
  output logic                         pat_we,
  output logic [fmi_pkg::PAT_AW-1:0]   pat_waddr,
  output logic [fmi_pkg::BYTE_W-1:0]   pat_wdata,
  output logic                         q_push,
  output fmi_pkg::cmd_t                q_cmd,
  input  logic                         q_full,
  input  fmi_pkg::back_status_t        bstat
);
  import fmi_pkg::*;

  logic [BYTE_W-1:0]  sent_r;
  logic [TEXT_AW-1:0] tlen_r;
  logic [PLEN_W-1:0]  plen_r;
  logic               tovf_r;
  logic               povf_r;
  logic               spend_r;
  logic [TEXT_AW-1:0] slen_r;
  logic               sovf_r;
  logic               bbusy_r;
  logic               sbusy_r;

  logic accept;
  logic t_room;
  logic p_room;

  assign t_room = (tlen_r < TEXT_AW'(TEXT_MAX - 1));
  assign p_room = (plen_r < PLEN_W'(PATTERN_MAX));

  assign in_stall = spend_r || q_full ||
                    ((in_operation == OP_TEXT) && bbusy_r) ||
                    ((in_operation == OP_PATTERN) && sbusy_r);
  assign accept = in_valid && !in_stall;

  always_comb begin
    if (spend_r) begin
      text_we    = 1'b1;
      text_waddr = slen_r;
      text_wdata = sent_r;
    end else begin
      text_we    = accept && (in_operation == OP_TEXT) && t_room;
      text_waddr = tlen_r;
      text_wdata = in_data_byte;
    end
    pat_we    = accept && (in_operation == OP_PATTERN) && p_room;
    pat_waddr = plen_r[PAT_AW-1:0];
    pat_wdata = in_data_byte;
  end

  always_comb begin
    q_push  = 1'b0;
    q_cmd   = '0;
    priority if (spend_r) begin
      q_push    = !q_full;
      q_cmd.op  = CMD_BUILD;
      q_cmd.len = CNT_W'(slen_r) + CNT_W'(1);
      q_cmd.ovf = sovf_r;
    end else if (accept && (in_operation == OP_PATTERN) && in_last) begin
      q_push    = 1'b1;
      q_cmd.op  = CMD_SEARCH;
      q_cmd.len = p_room ? CNT_W'(plen_r) + CNT_W'(1) : CNT_W'(plen_r);
      q_cmd.ovf = povf_r || !p_room;
    end else if (accept && (in_operation == OP_READ)) begin
      q_push    = 1'b1;
      q_cmd.op  = CMD_READ;
      q_cmd.row = in_sa_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r  <= SENT_RESET;
      tlen_r  <= '0;
      plen_r  <= '0;
      tovf_r  <= 1'b0;
      povf_r  <= 1'b0;
      spend_r <= 1'b0;
      slen_r  <= '0;
      sovf_r  <= 1'b0;
      bbusy_r <= 1'b0;
      sbusy_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        sent_r <= cfg_wdata;
      end
      if (bstat.build_done) begin
        bbusy_r <= 1'b0;
      end
      if (bstat.search_done) begin
        sbusy_r <= 1'b0;
      end
      if (spend_r && !q_full) begin
        spend_r <= 1'b0;
        bbusy_r <= 1'b1;
      end
      if (accept && (in_operation == OP_TEXT)) begin
        if (in_last) begin
          spend_r <= 1'b1;
          slen_r  <= t_room ? tlen_r + TEXT_AW'(1) : tlen_r;
          sovf_r  <= tovf_r || !t_room;
          tlen_r  <= '0;
          tovf_r  <= 1'b0;
        end else if (t_room) begin
          tlen_r <= tlen_r + TEXT_AW'(1);
        end else begin
          tovf_r <= 1'b1;
        end
      end
      if (accept && (in_operation == OP_PATTERN)) begin
        if (in_last) begin
          plen_r  <= '0;
          povf_r  <= 1'b0;
          sbusy_r <= 1'b1;
        end else if (p_room) begin
          plen_r <= plen_r + PLEN_W'(1);
        end else begin
          povf_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/fmi_back.sv @@
// ----------------------------------------------------------------------------
// fmi_back
// Execution engine: suffix sorting by prefix doubling, transform and
// symbol-start table, backward search and suffix-array reads.
// ----------------------------------------------------------------------------
module fmi_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  fmi_pkg::cmd_t                q_cmd,
  output logic                         q_pop,
  output logic [fmi_pkg::TEXT_AW-1:0]  text_raddr,
  input  logic [fmi_pkg::BYTE_W-1:0]   text_rdata,
  output logic [fmi_pkg::PAT_AW-1:0]   pat_raddr,
  input  logic [fmi_pkg::BYTE_W-1:0]   pat_rdata,
  output fmi_pkg::back_status_t        bstat,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_kind,
  output logic [fmi_pkg::CNT_W-1:0]    out_match_count,
  output logic [fmi_pkg::TEXT_AW-1:0]  out_range_start,
  output logic [fmi_pkg::TEXT_AW-1:0]  out_position,
  output logic                         out_overflow
);
  import fmi_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_INIT  = 5'd1;
  localparam logic [4:0] S_CLR   = 5'd2;
  localparam logic [4:0] S_CNT   = 5'd3;
  localparam logic [4:0] S_SUM   = 5'd4;
  localparam logic [4:0] S_PLACE = 5'd5;
  localparam logic [4:0] S_RANK  = 5'd6;
  localparam logic [4:0] S_COPY  = 5'd7;
  localparam logic [4:0] S_FCLR  = 5'd8;
  localparam logic [4:0] S_BWT   = 5'd9;
  localparam logic [4:0] S_SYM   = 5'd10;
  localparam logic [4:0] S_SRCH  = 5'd11;
  localparam logic [4:0] S_SCAN  = 5'd12;
  localparam logic [4:0] S_EVAL  = 5'd13;
  localparam logic [4:0] S_READ  = 5'd14;
  localparam logic [4:0] S_OUT   = 5'd15;

  logic [4:0]         st_r;
  logic [2:0]         ph_r;
  logic               sel_r;
  cmd_t               cmd_r;
  logic [CNT_W-1:0]   i_r, j_r, k_r, top_r, n_r, size_r, acc_r, key_r;
  logic [TEXT_AW-1:0] s_r;
  logic [CNT_W-1:0]   r1_r, r2_r, p1_r, p2_r, pn_r;
  logic [CNT_W-1:0]   lo_r, hi_r, base_r, call_r, clo_r, chi_r;
  logic [BYTE_W-1:0]  c_r;
  result_t            res_r;
  result_t            ores_r;
  logic               ovalid_r;
  logic               bdone_r, sdone_r;

  logic               rc_we, rn_we, bs_we, bk_we, sa_we, tf_we, ss_we;
  logic [TEXT_AW-1:0] rc_waddr, rc_raddr, rn_waddr, rn_raddr;
  logic [TEXT_AW-1:0] bs_waddr, bs_raddr, sa_waddr, sa_raddr, tf_waddr, tf_raddr;
  logic [CNT_W-1:0]   bk_waddr, bk_raddr;
  logic [SYM_AW-1:0]  ss_waddr, ss_raddr;
  logic [CNT_W-1:0]   rc_wdata, rc_rdata, rn_wdata, rn_rdata, bk_wdata, bk_rdata;
  logic [CNT_W-1:0]   ss_wdata, ss_rdata;
  logic [TEXT_AW-1:0] bs_wdata, bs_rdata, sa_wdata, sa_rdata;
  logic [BYTE_W-1:0]  tf_wdata, tf_rdata;

  logic [CNT_W:0]     ik, sk;
  logic               ik_in, sk_in;
  logic [CNT_W-1:0]   nm1, im1, szm1, bkdec, new_rank, nlo, nhi;
  logic [TEXT_AW-1:0] sm1;
  logic               eq;

  assign ik       = {1'b0, i_r} + {1'b0, k_r};
  assign sk       = (CNT_W + 1)'(s_r) + {1'b0, k_r};
  assign ik_in    = (ik < {1'b0, n_r});
  assign sk_in    = (sk < {1'b0, n_r});
  assign nm1      = n_r - CNT_W'(1);
  assign im1      = i_r - CNT_W'(1);
  assign szm1     = size_r - CNT_W'(1);
  assign sm1      = s_r - TEXT_AW'(1);
  assign bkdec    = bk_rdata - CNT_W'(1);
  assign new_rank = (i_r == '0) ? CNT_W'(1) :
                    pn_r + CNT_W'((r1_r != p1_r) || (r2_r != p2_r));
  assign nlo      = base_r + clo_r;
  assign nhi      = base_r + chi_r;
  assign eq       = (tf_rdata == c_r);

  assign q_pop = (st_r == S_IDLE) && !q_empty;

  always_comb begin
    rc_we = 1'b0; rc_waddr = '0; rc_wdata = '0; rc_raddr = '0;
    rn_we = 1'b0; rn_waddr = '0; rn_wdata = '0; rn_raddr = '0;
    bs_we = 1'b0; bs_waddr = '0; bs_wdata = '0; bs_raddr = '0;
    bk_we = 1'b0; bk_waddr = '0; bk_wdata = '0; bk_raddr = '0;
    sa_we = 1'b0; sa_waddr = '0; sa_wdata = '0; sa_raddr = '0;
    tf_we = 1'b0; tf_waddr = '0; tf_wdata = '0; tf_raddr = '0;
    ss_we = 1'b0; ss_waddr = '0; ss_wdata = '0; ss_raddr = '0;
    text_raddr = '0;
    pat_raddr  = '0;
    unique case (st_r)
      S_INIT: begin
        text_raddr = i_r[TEXT_AW-1:0];
        if (ph_r == 3'd1) begin
          rc_we    = 1'b1;
          rc_waddr = i_r[TEXT_AW-1:0];
          rc_wdata = CNT_W'(text_rdata) + CNT_W'(1);
        end
      end
      S_CLR, S_FCLR: begin
        bk_we    = 1'b1;
        bk_waddr = i_r;
      end
      S_CNT: begin
        rc_raddr = sel_r ? i_r[TEXT_AW-1:0] : ik[TEXT_AW-1:0];
        bk_raddr = key_r;
        if (ph_r == 3'd3) begin
          bk_we    = 1'b1;
          bk_waddr = key_r;
          bk_wdata = bk_rdata + CNT_W'(1);
        end
      end
      S_SUM: begin
        bk_raddr = i_r;
        if (ph_r == 3'd1) begin
          bk_we    = 1'b1;
          bk_waddr = i_r;
          bk_wdata = bk_rdata + acc_r;
        end
      end
      S_PLACE: begin
        bk_raddr = key_r;
        bs_raddr = i_r[TEXT_AW-1:0];
        rc_raddr = sel_r ? s_r : ik[TEXT_AW-1:0];
        if (!sel_r && ph_r == 3'd3) begin
          bk_we    = 1'b1;
          bk_waddr = key_r;
          bk_wdata = bkdec;
          bs_we    = 1'b1;
          bs_waddr = bkdec[TEXT_AW-1:0];
          bs_wdata = i_r[TEXT_AW-1:0];
        end
        if (sel_r && ph_r == 3'd5) begin
          bk_we    = 1'b1;
          bk_waddr = key_r;
          bk_wdata = bkdec;
          sa_we    = 1'b1;
          sa_waddr = bkdec[TEXT_AW-1:0];
          sa_wdata = s_r;
        end
      end
      S_RANK: begin
        sa_raddr = i_r[TEXT_AW-1:0];
        rc_raddr = (ph_r == 3'd3) ? sk[TEXT_AW-1:0] : s_r;
        if (ph_r == 3'd5) begin
          rn_we    = 1'b1;
          rn_waddr = s_r;
          rn_wdata = new_rank;
        end
      end
      S_COPY: begin
        rn_raddr = i_r[TEXT_AW-1:0];
        if (ph_r == 3'd1) begin
          rc_we    = 1'b1;
          rc_waddr = i_r[TEXT_AW-1:0];
          rc_wdata = rn_rdata;
        end
      end
      S_BWT: begin
        sa_raddr   = i_r[TEXT_AW-1:0];
        text_raddr = (s_r == '0) ? nm1[TEXT_AW-1:0] : sm1;
        bk_raddr   = key_r;
        if (ph_r == 3'd3) begin
          tf_we    = 1'b1;
          tf_waddr = i_r[TEXT_AW-1:0];
          tf_wdata = text_rdata;
        end
        if (ph_r == 3'd5) begin
          bk_we    = 1'b1;
          bk_waddr = key_r;
          bk_wdata = bk_rdata + CNT_W'(1);
        end
      end
      S_SYM: begin
        bk_raddr = i_r;
        if (ph_r == 3'd1) begin
          ss_we    = 1'b1;
          ss_waddr = i_r[SYM_AW-1:0];
          ss_wdata = acc_r;
        end
      end
      S_SRCH: begin
        pat_raddr = im1[PAT_AW-1:0];
        ss_raddr  = c_r;
      end
      S_SCAN: begin
        tf_raddr = j_r[TEXT_AW-1:0];
      end
      S_READ: begin
        sa_raddr = cmd_r.row;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      ph_r     <= '0;
      size_r   <= '0;
      ovalid_r <= 1'b0;
      bdone_r  <= 1'b0;
      sdone_r  <= 1'b0;
    end else begin
      bdone_r <= 1'b0;
      sdone_r <= 1'b0;
      if (ovalid_r && !out_stall) begin
        ovalid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r <= q_cmd;
            ph_r  <= '0;
            res_r <= '0;
            case (q_cmd.op)
              CMD_BUILD: begin
                n_r   <= q_cmd.len;
                i_r   <= '0;
                k_r   <= CNT_W'(1);
                top_r <= CNT_W'(SYM_N);
                st_r  <= S_INIT;
              end
              CMD_SEARCH: begin
                if (size_r == '0) begin
                  res_r.kind <= KIND_SEARCH;
                  res_r.ovf  <= q_cmd.ovf;
                  st_r       <= S_OUT;
                end else begin
                  lo_r <= '0;
                  hi_r <= size_r;
                  i_r  <= q_cmd.len;
                  st_r <= S_SRCH;
                end
              end
              CMD_READ: begin
                st_r <= S_READ;
              end
              default: begin
                st_r <= S_IDLE;
              end
            endcase
          end
        end
        S_INIT: begin
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1;
          end else begin
            ph_r <= 3'd0;
            if (i_r == nm1) begin
              st_r  <= S_CLR;
              sel_r <= 1'b0;
              i_r   <= '0;
            end else begin
              i_r <= i_r + CNT_W'(1);
            end
          end
        end
        S_CLR: begin
          if (i_r == top_r) begin
            st_r <= S_CNT;
            i_r  <= '0;
            ph_r <= '0;
          end else begin
            i_r <= i_r + CNT_W'(1);
          end
        end
        S_CNT: begin
          unique case (ph_r)
            3'd0: begin
              if (sel_r || ik_in) begin
                ph_r <= 3'd1;
              end else begin
                key_r <= '0;
                ph_r  <= 3'd2;
              end
            end
            3'd1: begin
              key_r <= rc_rdata;
              ph_r  <= 3'd2;
            end
            3'd2: ph_r <= 3'd3;
            default: begin
              ph_r <= '0;
              if (i_r == nm1) begin
                st_r  <= S_SUM;
                i_r   <= '0;
                acc_r <= '0;
              end else begin
                i_r <= i_r + CNT_W'(1);
              end
            end
          endcase
        end
        S_SUM: begin
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1;
          end else begin
            ph_r  <= 3'd0;
            acc_r <= bk_rdata + acc_r;
            if (i_r == top_r) begin
              st_r <= S_PLACE;
              i_r  <= nm1;
            end else begin
              i_r <= i_r + CNT_W'(1);
            end
          end
        end
        S_PLACE: begin
          if (!sel_r) begin
            unique case (ph_r)
              3'd0: begin
                if (ik_in) begin
                  ph_r <= 3'd1;
                end else begin
                  key_r <= '0;
                  ph_r  <= 3'd2;
                end
              end
              3'd1: begin
                key_r <= rc_rdata;
                ph_r  <= 3'd2;
              end
              3'd2: ph_r <= 3'd3;
              default: begin
                ph_r <= '0;
                if (i_r == '0) begin
                  st_r  <= S_CLR;
                  sel_r <= 1'b1;
                end else begin
                  i_r <= im1;
                end
              end
            endcase
          end else begin
            unique case (ph_r)
              3'd1: begin
                s_r  <= bs_rdata;
                ph_r <= 3'd2;
              end
              3'd3: begin
                key_r <= rc_rdata;
                ph_r  <= 3'd4;
              end
              3'd5: begin
                ph_r <= '0;
                if (i_r == '0) begin
                  st_r <= S_RANK;
                end else begin
                  i_r <= im1;
                end
              end
              default: ph_r <= ph_r + 3'd1;
            endcase
          end
        end
        S_RANK: begin
          unique case (ph_r)
            3'd1: begin
              s_r  <= sa_rdata;
              ph_r <= 3'd2;
            end
            3'd3: begin
              r1_r <= rc_rdata;
              if (sk_in) begin
                ph_r <= 3'd4;
              end else begin
                r2_r <= '0;
                ph_r <= 3'd5;
              end
            end
            3'd4: begin
              r2_r <= rc_rdata;
              ph_r <= 3'd5;
            end
            3'd5: begin
              p1_r  <= r1_r;
              p2_r  <= r2_r;
              pn_r  <= new_rank;
              top_r <= new_rank;
              ph_r  <= '0;
              if (i_r == nm1) begin
                st_r <= S_COPY;
                i_r  <= '0;
              end else begin
                i_r <= i_r + CNT_W'(1);
              end
            end
            default: ph_r <= ph_r + 3'd1;
          endcase
        end
        S_COPY: begin
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1;
          end else begin
            ph_r <= 3'd0;
            if (i_r == nm1) begin
              i_r <= '0;
              if ((top_r >= n_r) || (k_r >= n_r)) begin
                st_r <= S_FCLR;
              end else begin
                k_r   <= {k_r[CNT_W-2:0], 1'b0};
                sel_r <= 1'b0;
                st_r  <= S_CLR;
              end
            end else begin
              i_r <= i_r + CNT_W'(1);
            end
          end
        end
        S_FCLR: begin
          if (i_r == CNT_W'(SYM_N - 1)) begin
            st_r <= S_BWT;
            i_r  <= '0;
            ph_r <= '0;
          end else begin
            i_r <= i_r + CNT_W'(1);
          end
        end
        S_BWT: begin
          unique case (ph_r)
            3'd1: begin
              s_r  <= sa_rdata;
              ph_r <= 3'd2;
            end
            3'd3: begin
              key_r <= CNT_W'(text_rdata);
              ph_r  <= 3'd4;
            end
            3'd5: begin
              ph_r <= '0;
              if (i_r == nm1) begin
                st_r  <= S_SYM;
                i_r   <= '0;
                acc_r <= '0;
              end else begin
                i_r <= i_r + CNT_W'(1);
              end
            end
            default: ph_r <= ph_r + 3'd1;
          endcase
        end
        S_SYM: begin
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1;
          end else begin
            ph_r  <= 3'd0;
            acc_r <= acc_r + bk_rdata;
            if (i_r == CNT_W'(SYM_N - 1)) begin
              size_r     <= n_r;
              res_r.kind <= KIND_BUILT;
              res_r.ovf  <= cmd_r.ovf;
              st_r       <= S_OUT;
            end else begin
              i_r <= i_r + CNT_W'(1);
            end
          end
        end
        S_SRCH: begin
          unique case (ph_r)
            3'd0: begin
              if (i_r == '0) begin
                res_r.kind  <= KIND_SEARCH;
                res_r.count <= hi_r - lo_r;
                res_r.start <= lo_r[TEXT_AW-1:0];
                res_r.ovf   <= cmd_r.ovf;
                st_r        <= S_OUT;
              end else begin
                ph_r <= 3'd1;
              end
            end
            3'd1: begin
              c_r  <= pat_rdata;
              ph_r <= 3'd2;
            end
            3'd2: ph_r <= 3'd3;
            default: begin
              base_r <= ss_rdata;
              call_r <= '0;
              clo_r  <= '0;
              chi_r  <= '0;
              j_r    <= '0;
              ph_r   <= '0;
              st_r   <= S_SCAN;
            end
          endcase
        end
        S_SCAN: begin
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1;
          end else begin
            ph_r   <= 3'd0;
            call_r <= call_r + CNT_W'(eq);
            clo_r  <= clo_r + CNT_W'(eq && (j_r < lo_r));
            chi_r  <= chi_r + CNT_W'(eq && (j_r < hi_r));
            if (j_r == szm1) begin
              st_r <= S_EVAL;
            end else begin
              j_r <= j_r + CNT_W'(1);
            end
          end
        end
        S_EVAL: begin
          if ((call_r == '0) || (nlo >= nhi)) begin
            res_r.kind <= KIND_SEARCH;
            res_r.ovf  <= cmd_r.ovf;
            st_r       <= S_OUT;
          end else begin
            lo_r <= nlo;
            hi_r <= nhi;
            i_r  <= im1;
            ph_r <= '0;
            st_r <= S_SRCH;
          end
        end
        S_READ: begin
          res_r.kind <= KIND_POS;
          if (ph_r == 3'd0) begin
            if (CNT_W'(cmd_r.row) < size_r) begin
              ph_r <= 3'd1;
            end else begin
              st_r <= S_OUT;
            end
          end else begin
            res_r.pos <= sa_rdata;
            ph_r      <= '0;
            st_r      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid_r || !out_stall) begin
            ores_r   <= res_r;
            ovalid_r <= 1'b1;
            bdone_r  <= (res_r.kind == KIND_BUILT);
            sdone_r  <= (res_r.kind == KIND_SEARCH);
            st_r     <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign bstat.build_done  = bdone_r;
  assign bstat.search_done = sdone_r;

  assign out_valid       = ovalid_r;
  assign out_kind        = ores_r.kind;
  assign out_match_count = ores_r.count;
  assign out_range_start = ores_r.start;
  assign out_position    = ores_r.pos;
  assign out_overflow    = ores_r.ovf;

  fmi_ram #(.WIDTH(CNT_W), .DEPTH(TEXT_MAX)) u_rank_cur (
    .clk, .we(rc_we), .waddr(rc_waddr), .wdata(rc_wdata), .raddr(rc_raddr), .rdata(rc_rdata)
  );
  fmi_ram #(.WIDTH(CNT_W), .DEPTH(TEXT_MAX)) u_rank_new (
    .clk, .we(rn_we), .waddr(rn_waddr), .wdata(rn_wdata), .raddr(rn_raddr), .rdata(rn_rdata)
  );
  fmi_ram #(.WIDTH(TEXT_AW), .DEPTH(TEXT_MAX)) u_by_second (
    .clk, .we(bs_we), .waddr(bs_waddr), .wdata(bs_wdata), .raddr(bs_raddr), .rdata(bs_rdata)
  );
  fmi_ram #(.WIDTH(CNT_W), .DEPTH(BKT_DEPTH)) u_bucket (
    .clk, .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata), .raddr(bk_raddr), .rdata(bk_rdata)
  );
  fmi_ram #(.WIDTH(TEXT_AW), .DEPTH(TEXT_MAX)) u_suffix (
    .clk, .we(sa_we), .waddr(sa_waddr), .wdata(sa_wdata), .raddr(sa_raddr), .rdata(sa_rdata)
  );
  fmi_ram #(.WIDTH(BYTE_W), .DEPTH(TEXT_MAX)) u_transform (
    .clk, .we(tf_we), .waddr(tf_waddr), .wdata(tf_wdata), .raddr(tf_raddr), .rdata(tf_rdata)
  );
  fmi_ram #(.WIDTH(CNT_W), .DEPTH(SYM_N)) u_sym_start (
    .clk, .we(ss_we), .waddr(ss_waddr), .wdata(ss_wdata), .raddr(ss_raddr), .rdata(ss_rdata)
  );

endmodule

@@ sv/fm_index_backward_search.sv @@
// A build sorts the suffixes by prefix doubling in at most log2(n)+1 rounds,
// then forms the transform and symbol-start table (n = text + 1). A search
// scans the whole transform once per pattern byte; a row read is one lookup.
// These are walks over the one-read-port memories of the execution engine.
// Reset (rst_n low, synchronous) clears control state, lengths and flags and
// the terminator to 8'h24; memories are not cleared.
// ----------------------------------------------------------------------------
// fm_index_backward_search
// FM-index builder and backward search engine, top level.
// ----------------------------------------------------------------------------
module fm_index_backward_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_operation,
  input  logic [fmi_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                         in_last,
  input  logic [fmi_pkg::TEXT_AW-1:0]  in_sa_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_kind,
  output logic [fmi_pkg::CNT_W-1:0]    out_match_count,
  output logic [fmi_pkg::TEXT_AW-1:0]  out_range_start,
  output logic [fmi_pkg::TEXT_AW-1:0]  out_position,
  output logic                         out_overflow,
  input  logic                         cfg_we,
  input  logic [fmi_pkg::BYTE_W-1:0]   cfg_wdata
);
  import fmi_pkg::*;

  logic               text_we, pat_we;
  logic [TEXT_AW-1:0] text_waddr, text_raddr;
  logic [BYTE_W-1:0]  text_wdata, text_rdata, pat_wdata, pat_rdata;
  logic [PAT_AW-1:0]  pat_waddr, pat_raddr;
  logic               q_push, q_pop, q_empty, q_full;
  cmd_t               q_cmd, q_head;
  back_status_t       bstat;

  fmi_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation, .in_data_byte, .in_last,
    .in_sa_index, .cfg_we, .cfg_wdata, .text_we, .text_waddr, .text_wdata,
    .pat_we, .pat_waddr, .pat_wdata, .q_push, .q_cmd, .q_full, .bstat
  );

  fmi_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_cmd(q_cmd), .pop(q_pop), .head(q_head),
    .empty(q_empty), .full(q_full)
  );

  fmi_ram #(.WIDTH(BYTE_W), .DEPTH(TEXT_MAX)) u_text (
    .clk, .we(text_we), .waddr(text_waddr), .wdata(text_wdata), .raddr(text_raddr),
    .rdata(text_rdata)
  );

  fmi_ram #(.WIDTH(BYTE_W), .DEPTH(PATTERN_MAX)) u_pattern (
    .clk, .we(pat_we), .waddr(pat_waddr), .wdata(pat_wdata), .raddr(pat_raddr),
    .rdata(pat_rdata)
  );

  fmi_back u_back (
    .clk, .rst_n, .q_empty, .q_cmd(q_head), .q_pop, .text_raddr, .text_rdata,
    .pat_raddr, .pat_rdata, .bstat, .out_valid, .out_stall, .out_kind,
    .out_match_count, .out_range_start, .out_position, .out_overflow
  );

endmodule

@@ sv/fmi_checker.sv @@
// ----------------------------------------------------------------------------
// fmi_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module fmi_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  out_kind,
  input logic [fmi_pkg::CNT_W-1:0]   out_match_count,
  input logic [fmi_pkg::TEXT_AW-1:0] out_range_start,
  input logic [fmi_pkg::TEXT_AW-1:0] out_position,
  input logic                        out_overflow
);
  import fmi_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_match_count) && $stable(out_range_start) && $stable(out_position))
    else $error("result changed while stalled");

  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_POS) |->
      (out_match_count == '0) && (out_range_start == '0) && !out_overflow)
    else $error("position result carries search fields");

  a_built: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_BUILT) |->
      (out_match_count == '0) && (out_range_start == '0) && (out_position == '0))
    else $error("build result carries data fields");

  a_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_SEARCH) && (out_match_count == '0) |->
      (out_range_start == '0) && (out_position == '0))
    else $error("empty search result with nonzero range");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fm_index_backward_search fmi_checker u_fmi_checker (.*);

@@ test/tb_fm_index_backward_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fm_index_backward_search
// Self-checking bench for the FM-index engine: text loads, index builds,
// backward searches and suffix-array reads are predicted in the bench and
// every result transaction is compared field by field, under random idling
// on both channels and several terminator settings.
// ----------------------------------------------------------------------------
module tb_fm_index_backward_search;
  import fmi_pkg::*;

  localparam longint CYCLE_LIMIT = 5_000_000;

  typedef bit [7:0] bytes_t[$];

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_operation = OP_TEXT;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic                in_last = 1'b0;
  logic [TEXT_AW-1:0]  in_sa_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_kind;
  logic [CNT_W-1:0]    out_match_count;
  logic [TEXT_AW-1:0]  out_range_start;
  logic [TEXT_AW-1:0]  out_position;
  logic                out_overflow;
  logic                cfg_we = 1'b0;
  logic [BYTE_W-1:0]   cfg_wdata = '0;

  fm_index_backward_search dut (.*);

  always #6 clk = ~clk;

  // index model state
  bit [7:0] text_mem[TEXT_MAX];
  int       text_len;
  bit       text_drop;
  int       sa_rows[TEXT_MAX];
  int       merge_tmp[TEXT_MAX];
  bit [7:0] bwt_mem[TEXT_MAX];
  int       sym_first[SYM_N];
  bit [7:0] pat_mem[PATTERN_MAX];
  int       pat_len;
  bit       pat_drop;
  int       index_len;
  bit [7:0] terminator = SENT_RESET;
  bytes_t   indexed_text;

  result_t  pending_results[$];
  int       errors;
  int       items_sent;
  bit       no_idle;
  int       out_hold;
  longint   cycles;

  function automatic bit suffix_less(int a, int b, int n);
    while (a < n && b < n) begin
      if (text_mem[a] != text_mem[b]) return text_mem[a] < text_mem[b];
      a++;
      b++;
    end
    return a >= n;
  endfunction

  function automatic void build_fm_index();
    int n, w, lo, mid, hi, i, j, k, s, total;
    int freq[SYM_N];
    n = text_len + 1;
    text_mem[text_len] = terminator;
    for (i = 0; i < n; i++) sa_rows[i] = i;
    for (w = 1; w < n; w = w * 2) begin
      for (lo = 0; lo < n; lo = lo + 2 * w) begin
        mid = (lo + w < n) ? lo + w : n;
        hi  = (lo + 2 * w < n) ? lo + 2 * w : n;
        i = lo;
        j = mid;
        for (k = lo; k < hi; k++) begin
          if (i < mid && (j >= hi || !suffix_less(sa_rows[j], sa_rows[i], n))) begin
            merge_tmp[k] = sa_rows[i];
            i++;
          end else begin
            merge_tmp[k] = sa_rows[j];
            j++;
          end
        end
      end
      for (i = 0; i < n; i++) sa_rows[i] = merge_tmp[i];
    end
    for (i = 0; i < SYM_N; i++) freq[i] = 0;
    for (i = 0; i < n; i++) begin
      s = sa_rows[i];
      bwt_mem[i] = text_mem[(s == 0) ? n - 1 : s - 1];
      freq[bwt_mem[i]]++;
    end
    total = 0;
    for (i = 0; i < SYM_N; i++) begin
      sym_first[i] = total;
      total += freq[i];
    end
    index_len = n;
    indexed_text = {};
    for (i = 0; i < n; i++) indexed_text = {indexed_text, text_mem[i]};
  endfunction

  function automatic int occ_before(bit [7:0] c, int upto);
    int cnt;
    cnt = 0;
    for (int i = 0; i < upto && i < index_len; i++)
      if (bwt_mem[i] == c) cnt++;
    return cnt;
  endfunction

  function automatic void backward_search(output int count, output int first_row);
    int lo, hi;
    bit [7:0] c;
    count = 0;
    first_row = 0;
    lo = 0;
    hi = index_len;
    if (index_len == 0) return;
    for (int i = pat_len - 1; i >= 0; i--) begin
      c = pat_mem[i];
      if (occ_before(c, index_len) == 0) return;
      lo = sym_first[c] + occ_before(c, lo);
      hi = sym_first[c] + occ_before(c, hi);
      if (lo >= hi) return;
    end
    count = hi - lo;
    first_row = lo;
  endfunction

  function automatic void predict_item(logic [1:0] op, bit [7:0] b, bit last,
                                       int row);
    result_t r;
    int cnt, first_row;
    r = '0;
    case (op)
      OP_TEXT: begin
        if (text_len < TEXT_MAX - 1) begin
          text_mem[text_len] = b;
          text_len++;
        end else text_drop = 1'b1;
        if (last) begin
          build_fm_index();
          r.kind = KIND_BUILT;
          r.ovf = text_drop;
          text_drop = 1'b0;
          text_len = 0;
          pending_results = {pending_results, r};
        end
      end
      OP_PATTERN: begin
        if (pat_len < PATTERN_MAX) begin
          pat_mem[pat_len] = b;
          pat_len++;
        end else pat_drop = 1'b1;
        if (last) begin
          backward_search(cnt, first_row);
          r.kind = KIND_SEARCH;
          r.count = CNT_W'(cnt);
          r.start = TEXT_AW'(first_row);
          r.ovf = pat_drop;
          pat_drop = 1'b0;
          pat_len = 0;
          pending_results = {pending_results, r};
        end
      end
      OP_READ: begin
        r.kind = KIND_POS;
        r.pos = (row < index_len) ? TEXT_AW'(sa_rows[row]) : '0;
        pending_results = {pending_results, r};
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transaction, kind %0d", $time, out_kind);
          errors++;
        end else begin
          result_t e;
          e = pending_results.pop_front();
          if (out_kind !== e.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, e.kind, out_kind);
            errors++;
          end
          if (out_match_count !== e.count) begin
            $display("%0t: match_count expected %0d actual %0d", $time, e.count,
                     out_match_count);
            errors++;
          end
          if (out_range_start !== e.start) begin
            $display("%0t: range_start expected %0d actual %0d", $time, e.start,
                     out_range_start);
            errors++;
          end
          if (out_position !== e.pos) begin
            $display("%0t: position expected %0d actual %0d", $time, e.pos,
                     out_position);
            errors++;
          end
          if (out_overflow !== e.ovf) begin
            $display("%0t: overflow expected %0d actual %0d", $time, e.ovf,
                     out_overflow);
            errors++;
          end
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_hold = pick_gap();
        out_stall <= (out_hold > 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, bit [7:0] b, bit last, int row);
    int g;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_data_byte <= b;
    in_last      <= last;
    in_sa_index  <= row[TEXT_AW-1:0];
    do @(posedge clk); while (in_stall);
    predict_item(op, b, last, row);
    if (op != OP_UNUSED) items_sent++;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_seq(logic [1:0] op, bytes_t s);
    foreach (s[i]) send_item(op, s[i], i == s.size() - 1, $urandom_range(0, 4095));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_terminator(bit [7:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    terminator = v;
  endtask

  task automatic test_no_index();
    send_item(OP_PATTERN, "a", 1'b1, 0);
    send_item(OP_READ, 8'h00, 1'b0, 0);
    send_item(OP_UNUSED, 8'hFF, 1'b1, 4095);
  endtask

  task automatic test_small_text();
    send_seq(OP_TEXT, bytes_t'({"b", "a", "n", "a", "n", "a"}));
    send_seq(OP_PATTERN, bytes_t'({"a", "n", "a"}));
    send_seq(OP_PATTERN, bytes_t'({"x"}));
    send_seq(OP_PATTERN, bytes_t'({"b", "a", "n", "a", "n", "a"}));
    for (int r = 0; r <= 7; r++) send_item(OP_READ, 8'h00, 1'b1, r);
    send_item(OP_READ, 8'hA5, 1'b0, 4095);
  endtask

  task automatic test_terminator();
    set_terminator(8'h00);
    send_seq(OP_TEXT, bytes_t'({8'hFF, 8'h00, 8'hFF, 8'h80}));
    send_seq(OP_PATTERN, bytes_t'({8'h00, 8'hFF}));
    send_item(OP_READ, 8'h00, 1'b0, 2);
    set_terminator(8'hFF);
    send_seq(OP_TEXT, bytes_t'({8'h00, 8'hFF, 8'h7F}));
    send_seq(OP_PATTERN, bytes_t'({8'hFF}));
    send_item(OP_READ, 8'h00, 1'b0, 3);
    set_terminator(SENT_RESET);
  endtask

  task automatic test_long_pattern();
    bytes_t p;
    send_seq(OP_TEXT, bytes_t'({"a", "a", "a"}));
    for (int i = 0; i < PATTERN_MAX + 2; i++) p = {p, 8'("a")};
    send_seq(OP_PATTERN, p);
    send_seq(OP_PATTERN, bytes_t'({"a", "a"}));
  endtask

  task automatic test_random();
    bytes_t s;
    int kind, len, st;
    bit wide;
    bit paused;
    paused = 1'b0;
    items_sent = 0;
    while (items_sent < 30) begin
      if (items_sent % 10 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (!paused && items_sent >= 15) begin
        drain();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 9);
      wide = ($urandom_range(0, 3) == 0);
      s = {};
      case (kind)
        0, 1, 2: begin
          len = $urandom_range(1, 16);
          for (int i = 0; i < len; i++)
            s = {s, 8'(wide ? $urandom_range(0, 255) : $urandom_range("a", "d"))};
          send_seq(OP_TEXT, s);
        end
        3, 4, 5: begin
          if (!wide && indexed_text.size() > 0) begin
            st = $urandom_range(0, indexed_text.size() - 1);
            len = $urandom_range(1, 4);
            for (int i = st; i < st + len && i < indexed_text.size(); i++)
              s = {s, indexed_text[i]};
          end else begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
              s = {s, 8'(wide ? $urandom_range(0, 255) : $urandom_range("a", "d"))};
          end
          send_seq(OP_PATTERN, s);
        end
        6, 7: send_item(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        wide ? $urandom_range(0, 4095) : $urandom_range(0, index_len + 1));
        8: send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), $urandom_range(0, 4095));
        default: begin
          case ($urandom_range(0, 2))
            0: set_terminator(8'h00);
            1: set_terminator(8'hFF);
            default: set_terminator(8'($urandom_range(0, 255)));
          endcase
        end
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_index();
    test_small_text();
    test_terminator();
    test_long_pattern();
    test_random();
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ fm_index_backward_search.f @@
sv/fmi_pkg.sv
sv/fmi_ram.sv
sv/fmi_queue.sv
sv/fmi_front.sv
sv/fmi_back.sv
sv/fm_index_backward_search.sv
sv/fmi_checker.sv
test/tb_fm_index_backward_search.sv
